@@ rtl/sha1s_pkg.sv @@
package sha1s_pkg;

  typedef logic [31:0] word_t;

  // Input transaction: one optional message byte and an end-of-message mark
  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       final_item;
  } in_item_t;

  // Output transaction: one digest word
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        last_word;
  } out_item_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FIN,
    ST_DONE
  } state_e;

  // Source of the byte shifted into the block register
  typedef enum logic [1:0] {
    BSEL_MSG,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } bsel_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic       shift_en;
    bsel_e      byte_sel;
    logic [2:0] len_idx;
    logic       round_en;
    logic [1:0] stage;
    logic       fin_add;
    logic       load_out;
    logic       restart;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_busy;
  } sts_t;

  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] WORD_LAST  = 3'd4;
  localparam logic [7:0] PAD_MARK   = 8'h80;

  localparam word_t SHA1_IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t SHA1_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

endpackage

@@ rtl/sha1s_ctrl.sv @@
module sha1s_ctrl import sha1s_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     byte_present_i,
  input  logic     final_item_i,
  output logic     in_stall_o,
  input  sts_t     sts_i,
  output cmd_t     cmd_o
);

  state_e     state_q, state_d;
  logic [5:0] fill_q, fill_d;
  logic [6:0] rnd_q, rnd_d;
  logic       pad_q, pad_d;
  logic       mark_q, mark_d;
  logic       lenblk_q, lenblk_d;
  logic       acc;

  assign acc = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (byte_present_i && fill_q == FILL_LAST) begin
            state_d = ST_ROUND;
          end else if (final_item_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_q == FILL_LAST) state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_q == ROUND_LAST) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (lenblk_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && byte_present_i) begin
          cmd_o.shift_en = 1'b1;
          cmd_o.byte_sel = BSEL_MSG;
        end
      end
      ST_PAD: begin
        cmd_o.shift_en = 1'b1;
        cmd_o.len_idx  = fill_q[2:0];
        if (!mark_q) begin
          cmd_o.byte_sel = BSEL_MARK;
        end else if (lenblk_q && fill_q >= LEN_OFFSET) begin
          cmd_o.byte_sel = BSEL_LEN;
        end else begin
          cmd_o.byte_sel = BSEL_ZERO;
        end
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        if (rnd_q < 7'd20) begin
          cmd_o.stage = 2'd0;
        end else if (rnd_q < 7'd40) begin
          cmd_o.stage = 2'd1;
        end else if (rnd_q < 7'd60) begin
          cmd_o.stage = 2'd2;
        end else begin
          cmd_o.stage = 2'd3;
        end
      end
      ST_FIN: begin
        cmd_o.fin_add = 1'b1;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          cmd_o.restart  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Fill, round and padding bookkeeping
  always_comb begin
    fill_d   = cmd_o.shift_en ? fill_q + 6'd1 : fill_q;
    rnd_d    = rnd_q;
    pad_d    = pad_q;
    mark_d   = mark_q;
    lenblk_d = lenblk_q;
    if (cmd_o.round_en) begin
      rnd_d = (rnd_q == ROUND_LAST) ? 7'd0 : rnd_q + 7'd1;
    end
    if (acc && final_item_i) begin
      pad_d    = 1'b1;
      mark_d   = 1'b0;
      lenblk_d = 1'b0;
    end
    // the length fits in this block only if the mark lands before the length field
    if (state_q == ST_PAD && !mark_q) begin
      mark_d   = 1'b1;
      lenblk_d = (fill_q < LEN_OFFSET);
    end
    if (state_q == ST_FIN && pad_q && !lenblk_q) lenblk_d = 1'b1;
    if (cmd_o.restart) pad_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      rnd_q    <= '0;
      pad_q    <= 1'b0;
      mark_q   <= 1'b0;
      lenblk_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      rnd_q    <= rnd_d;
      pad_q    <= pad_d;
      mark_q   <= mark_d;
      lenblk_q <= lenblk_d;
    end
  end

endmodule

@@ rtl/sha1s_dp.sv @@
module sha1s_dp import sha1s_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] message_byte_i,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_item_t  out_item_o
);

  // Block register: 64 bytes, later the rolling 16-word schedule; W[0] in the top word
  logic [511:0] blk_q, blk_d;
  word_t        chain_q [5];
  word_t        chain_d [5];
  word_t        work_q [5];
  word_t        work_d [5];
  word_t        dig_q [5];
  word_t        dig_d [5];
  logic [63:0]  bitcnt_q, bitcnt_d;
  logic [2:0]   ocnt_q, ocnt_d;
  logic         ovld_q, ovld_d;

  logic [7:0]   byte_in;
  logic [63:0]  len_sh;
  word_t        w_cur, w_mix, w_new, f_val, t_val;
  logic         out_acc;

  // Byte source selection
  assign len_sh = bitcnt_q >> {~cmd_i.len_idx, 3'b000};
  always_comb begin
    case (cmd_i.byte_sel)
      BSEL_MSG:  byte_in = message_byte_i;
      BSEL_MARK: byte_in = PAD_MARK;
      BSEL_LEN:  byte_in = len_sh[7:0];
      default:   byte_in = 8'h00;
    endcase
  end

  // Schedule expansion and round function
  assign w_cur = blk_q[511:480];
  assign w_mix = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    case (cmd_i.stage)
      2'd0:    f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      2'd2:    f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3])
                     | (work_q[2] & work_q[3]);
      default: f_val = work_q[1] ^ work_q[2] ^ work_q[3];
    endcase
  end

  assign t_val = {work_q[0][26:0], work_q[0][31:27]} + f_val + work_q[4]
               + SHA1_K[cmd_i.stage] + w_cur;

  // Block, chaining and working registers
  always_comb begin
    blk_d    = blk_q;
    bitcnt_d = bitcnt_q;
    chain_d  = chain_q;
    work_d   = work_q;
    if (cmd_i.shift_en) begin
      blk_d = {blk_q[503:0], byte_in};
      if (cmd_i.byte_sel == BSEL_MSG) bitcnt_d = bitcnt_q + 64'd8;
    end
    if (cmd_i.round_en) begin
      blk_d     = {blk_q[479:0], w_new};
      work_d[0] = t_val;
      work_d[1] = work_q[0];
      work_d[2] = {work_q[1][1:0], work_q[1][31:2]};
      work_d[3] = work_q[2];
      work_d[4] = work_q[3];
    end
    if (cmd_i.fin_add) begin
      for (int i = 0; i < 5; i++) begin
        chain_d[i] = chain_q[i] + work_q[i];
        work_d[i]  = chain_q[i] + work_q[i];
      end
    end
    if (cmd_i.restart) begin
      chain_d  = SHA1_IV;
      work_d   = SHA1_IV;
      bitcnt_d = '0;
    end
  end

  // Digest output buffer
  assign out_acc = ovld_q && !out_stall_i;
  always_comb begin
    dig_d  = dig_q;
    ocnt_d = ocnt_q;
    ovld_d = ovld_q;
    if (cmd_i.load_out) begin
      dig_d  = chain_q;
      ocnt_d = '0;
      ovld_d = 1'b1;
    end else if (out_acc) begin
      for (int i = 0; i < 4; i++) dig_d[i] = dig_q[i+1];
      if (ocnt_q == WORD_LAST) begin
        ocnt_d = '0;
        ovld_d = 1'b0;
      end else begin
        ocnt_d = ocnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    dig_q <= dig_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q  <= SHA1_IV;
      work_q   <= SHA1_IV;
      bitcnt_q <= '0;
      ocnt_q   <= '0;
      ovld_q   <= 1'b0;
    end else begin
      chain_q  <= chain_d;
      work_q   <= work_d;
      bitcnt_q <= bitcnt_d;
      ocnt_q   <= ocnt_d;
      ovld_q   <= ovld_d;
    end
  end

  assign sts_o.out_busy         = ovld_q;
  assign out_valid_o            = ovld_q;
  assign out_item_o.digest_word = dig_q[0];
  assign out_item_o.word_number = ocnt_q;
  assign out_item_o.last_word   = (ocnt_q == WORD_LAST);

endmodule

@@ rtl/sha1_stream_hash.sv @@
// SHA-1 digest of a byte stream.
// Input channel (in_valid_i / in_stall_o / in_item_i): each transaction carries an
// optional message byte and a final flag; a final transaction with no byte ends the
// message as is, so an empty message is a single such transaction.
// Output channel (out_valid_o / out_stall_i / out_item_o): five transactions per
// message, digest words 0..4, most significant first, last_word set on word 4.
// Operation: bytes are taken while in_stall_o is low. Every 64th byte starts the
// block compression, 80 rounds on one round unit at one round per cycle followed by
// the chaining add, with the input stalled meanwhile. After a final transaction the
// padding bytes are shifted in one per cycle and one or two blocks are compressed:
// one when the 0x80 mark lands on byte 55 or earlier, two when it lands on byte 56 or
// later. The digest words then follow one per cycle while out_stall_i is low.
// The digest sits in its own output buffer, so the next message streams in while the
// words are still being read; a later message that finishes before the buffer drains
// waits with in_stall_o high. A stall on the output just holds the current word.
// Reset clears the message state to the initial vector and empties the output buffer.
module sha1_stream_hash import sha1s_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  cmd_t cmd;
  sts_t sts;

  sha1s_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .byte_present_i (in_item_i.byte_present),
    .final_item_i   (in_item_i.final_item),
    .in_stall_o     (in_stall_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  sha1s_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .message_byte_i (in_item_i.message_byte),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .out_item_o     (out_item_o)
  );

endmodule

@@ rtl/sha1s_chk.sv @@
module sha1s_chk import sha1s_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // Stalled output transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled digest word changed");

  // A digest always starts at word 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> out_item_o.word_number == 3'd0)
    else $error("digest did not start at word 0");

  // Words follow one another without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last_word |=>
      out_valid_o && out_item_o.word_number == $past(out_item_o.word_number) + 3'd1)
    else $error("digest word sequence broken");

  // last_word marks word 4 only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.last_word == (out_item_o.word_number == 3'd4))
    else $error("last_word mismatch");

  // A final transaction is followed by padding, so input stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.final_item |=> in_stall_o)
    else $error("input taken during padding");

endmodule

bind sha1_stream_hash sha1s_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

@@ bench/tb_sha1_stream_hash.sv @@
module tb_sha1_stream_hash;
  import sha1s_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 400;
  localparam int ITEM_TARGET    = 120;

  // Digest predictor and expected-word store
  class sha1_digest_board;
    word_t       chain[5];
    logic [7:0]  block_bytes[64];
    int unsigned fill;
    logic [63:0] bit_count;
    out_item_t   pending_words[$];
    int          mismatch_count;
    int          words_seen;

    function new();
      mismatch_count = 0;
      words_seen     = 0;
      fresh_message();
    endfunction

    function void fresh_message();
      for (int i = 0; i < 5; i++) chain[i] = SHA1_IV[i];
      fill      = 0;
      bit_count = '0;
    endfunction

    function word_t rotl(word_t x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    // 80 rounds over the buffered block, added into the chaining words
    function void run_rounds();
      word_t w[16];
      word_t a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
        w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int i = 0; i < 80; i++) begin
        if (i >= 16)
          w[i & 15] = rotl(w[(i-3) & 15] ^ w[(i-8) & 15] ^ w[(i-14) & 15] ^ w[i & 15], 1);
        if (i < 20)      f = (b & c) | (~b & d);
        else if (i < 40) f = b ^ c ^ d;
        else if (i < 60) f = (b & c) | (b & d) | (c & d);
        else             f = b ^ c ^ d;
        k = SHA1_K[i / 20];
        t = rotl(a, 5) + f + e + k + w[i & 15];
        e = d; d = c; c = rotl(b, 30); b = a; a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    function void push_byte(logic [7:0] value);
      block_bytes[fill] = value;
      fill++;
      if (fill == 64) begin
        run_rounds();
        fill = 0;
      end
    endfunction

    // Accepted input transaction: absorb the byte, pad and emit on the final one
    function void note_item(in_item_t item);
      logic [63:0] length_bits;
      if (item.byte_present) begin
        push_byte(item.message_byte);
        bit_count += 64'd8;
      end
      if (!item.final_item) return;
      length_bits = bit_count;
      push_byte(PAD_MARK);
      while (fill != LEN_OFFSET) push_byte(8'h00);
      for (int i = 0; i < 8; i++) push_byte(length_bits[63 - 8*i -: 8]);
      for (int i = 0; i < 5; i++) begin
        out_item_t word;
        word.digest_word = chain[i];
        word.word_number = 3'(i);
        word.last_word   = (3'(i) == WORD_LAST);
        pending_words.push_back(word);
      end
      fresh_message();
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
    endtask

    // Accepted output transaction against the oldest expected word
    task check_word(out_item_t got);
      out_item_t want;
      words_seen++;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("word %0d unexpected: %h/%0d/%0b", words_seen,
                                  got.digest_word, got.word_number, got.last_word));
        return;
      end
      want = pending_words.pop_front();
      if (got.digest_word !== want.digest_word)
        report_mismatch($sformatf("word %0d digest_word %h, expected %h", words_seen,
                                  got.digest_word, want.digest_word));
      if (got.word_number !== want.word_number)
        report_mismatch($sformatf("word %0d word_number %0d, expected %0d", words_seen,
                                  got.word_number, want.word_number));
      if (got.last_word !== want.last_word)
        report_mismatch($sformatf("word %0d last_word %0b, expected %0b", words_seen,
                                  got.last_word, want.last_word));
    endtask
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  int in_gap_pct    = 9;
  int out_stall_pct = 9;
  int idle_cycles   = 0;

  sha1_digest_board board = new();

  sha1_stream_hash i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Transaction monitors and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_item(in_item_i);
      if (out_valid_o && !out_stall_i) board.check_word(out_item_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  function automatic in_item_t make_item(logic [7:0] value, logic present, logic last);
    in_item_t item;
    item.message_byte = value;
    item.byte_present = present;
    item.final_item   = last;
    return item;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(in_item_t item);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Random message with occasional ignored filler transactions
  task automatic send_message(int length, bit byte_on_final, ref int sent);
    for (int i = 0; i < length; i++) begin
      logic last;
      last = byte_on_final && (i == length - 1);
      if ($urandom_range(99) < 6) begin
        send_item(make_item(8'($urandom), 1'b0, 1'b0));
      end
      send_item(make_item(8'($urandom), 1'b1, last));
      sent++;
    end
    if (!byte_on_final || length == 0) begin
      send_item(make_item(8'($urandom), 1'b0, 1'b1));
      sent++;
    end
  endtask

  initial begin
    int sent;
    int length;
    int pick;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty message, filler, "abc" both ways, extreme bytes
    send_item(make_item(8'hFF, 1'b0, 1'b1));
    send_item(make_item(8'hA5, 1'b0, 1'b0));
    send_item(make_item(8'h61, 1'b1, 1'b0));
    send_item(make_item(8'h62, 1'b1, 1'b0));
    send_item(make_item(8'h63, 1'b1, 1'b1));
    send_item(make_item(8'h61, 1'b1, 1'b0));
    send_item(make_item(8'h62, 1'b1, 1'b0));
    send_item(make_item(8'h00, 1'b0, 1'b0));
    send_item(make_item(8'h63, 1'b1, 1'b0));
    send_item(make_item(8'h00, 1'b0, 1'b1));
    send_item(make_item(8'h00, 1'b1, 1'b1));
    send_item(make_item(8'hFF, 1'b1, 1'b0));
    send_item(make_item(8'h5A, 1'b0, 1'b1));
    send_item(make_item(8'h00, 1'b0, 1'b1));
    // the directed transactions above
    sent = 14;

    // Random messages, lengths weighted toward short ones and the padding boundaries
    while (sent < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 60)      length = $urandom_range(8, 0);
      else if (pick < 85) length = $urandom_range(65, 54);
      else if (pick < 95) length = $urandom_range(53, 9);
      else                length = $urandom_range(129, 119);
      if (length > ITEM_TARGET - sent) length = ITEM_TARGET - sent;
      // no back-pressure or gaps for a long stretch in the middle of the run
      if (sent >= 40 && sent < 80) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = 9;
        out_stall_pct = 9;
      end
      send_message(length, 1'($urandom_range(1)), sent);
    end
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.pending() != 0)
      board.report_mismatch($sformatf("%0d digest words never arrived", board.pending()));
    if (board.mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
